// ===== rtl/rsufh_pkg.sv =====
// Shared types, codes and command table for the radon sensor link handler.
// No dependencies; imported by radon_sensor_uart_frame_handler.
package rsufh_pkg;

    // Input word layout: mode [1:0], command_select [3:2], rx_byte [11:4]
    localparam int S_DATA_W = 16;
    // Result word layout: kind [2:0], tx_byte [10:3], status [18:11],
    // minutes [26:19], value_integer [34:27], value_decimal [42:35], error [44:43]
    localparam int M_DATA_W = 48;

    localparam int FRAME_LEN = 8;
    localparam int CMD_LEN   = 4;

    typedef enum logic [1:0] {
        MODE_RX_BYTE = 2'd0,
        MODE_START   = 2'd1,
        MODE_PULL    = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        KIND_ACCEPTED = 3'd0,
        KIND_TX_BYTE  = 3'd1,
        KIND_TX_DONE  = 3'd2,
        KIND_READING  = 3'd3,
        KIND_REJECTED = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_HEADER    = 2'd1,
        ERR_HANDS_OFF = 2'd2,
        ERR_CHECKSUM  = 2'd3
    } err_t;

    localparam logic [1:0] CMD_REQUEST = 2'd0;
    localparam logic [1:0] CMD_RESET   = 2'd1;
    localparam logic [1:0] CMD_PERIOD  = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    localparam logic [7:0] HDR_START     = 8'h02;
    localparam logic [7:0] HDR_CMD       = 8'h10;
    localparam logic [7:0] HDR_LEN       = 8'h04;
    localparam logic [7:0] STAT_HANDSOFF = 8'hE0;
    localparam logic [7:0] CSUM_BASE     = 8'hFF;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] tx_byte;
        logic [7:0] status;
        logic [7:0] minutes;
        logic [7:0] val_int;
        logic [7:0] val_dec;
        err_t       err;
    } result_t;

    function automatic logic [7:0] cmd_byte(input logic [1:0] cmd, input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (cmd)
            CMD_REQUEST: begin
                case (idx)
                    2'd0: b = 8'h02;
                    2'd1: b = 8'h01;
                    2'd2: b = 8'h00;
                    default: b = 8'hFE;
                endcase
            end
            CMD_RESET: begin
                case (idx)
                    2'd0: b = 8'h02;
                    2'd1: b = 8'hA0;
                    2'd2: b = 8'h00;
                    default: b = 8'h5F;
                endcase
            end
            CMD_PERIOD: begin
                case (idx)
                    2'd0: b = 8'h02;
                    2'd1: b = 8'hA1;
                    2'd2: b = 8'h01;
                    default: b = 8'h5D;
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/radon_sensor_uart_frame_handler.sv =====
// Radon sensor link handler: command transmit sequencing and 8-byte frame check.
// Depends on rsufh_pkg.
// Each result word is registered: it appears on the m_ side the cycle after its input is taken.
// Throughput: one input word per cycle; a single result register decouples the
// two sides, and s_tready drops only while that register is full and stalled.
// Reset (synchronous, aresetn low): receive position and transmit index clear,
// the reset command is selected, the result register empties.
// Frame bytes hold no reset value; each is written before it is checked.
module radon_sensor_uart_frame_handler
    import rsufh_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // mode [1:0], command_select [3:2], rx_byte [11:4]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // result_kind [2:0], tx_byte [10:3],
                                           // sensor_status [18:11], elapsed_minutes [26:19],
                                           // value_integer [34:27], value_decimal [42:35],
                                           // error_code [44:43]
);

    logic [7:0] frame_reg [FRAME_LEN-1];
    logic [2:0] rx_pos_reg, rx_pos_next;
    logic [1:0] cmd_reg, cmd_next;
    logic [2:0] tx_idx_reg, tx_idx_next;
    logic       out_valid_reg;
    result_t    res_reg, res_next;
    logic       store_we;

    logic       accept;
    logic [1:0] in_mode;
    logic [1:0] in_sel;
    logic [7:0] in_byte;
    logic [7:0] sum;
    logic [7:0] expect_csum;

    assign in_mode = s_tdata[1:0];
    assign in_sel  = s_tdata[3:2];
    assign in_byte = s_tdata[11:4];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign sum = HDR_CMD + HDR_LEN + frame_reg[3] + frame_reg[4] + frame_reg[5] + frame_reg[6];
    assign expect_csum = CSUM_BASE - sum;

    always_comb begin
        rx_pos_next = rx_pos_reg;
        cmd_next    = cmd_reg;
        tx_idx_next = tx_idx_reg;
        store_we    = 1'b0;
        res_next    = '0;
        res_next.kind = KIND_ACCEPTED;
        case (in_mode)
            MODE_RX_BYTE: begin
                if (rx_pos_reg != 3'(FRAME_LEN-1)) begin
                    store_we    = 1'b1;
                    rx_pos_next = rx_pos_reg + 3'd1;
                end else begin
                    // last byte: check frame and resync
                    rx_pos_next      = '0;
                    res_next.status  = frame_reg[3];
                    res_next.minutes = frame_reg[4];
                    res_next.val_int = frame_reg[5];
                    res_next.val_dec = frame_reg[6];
                    if (frame_reg[0] != HDR_START || frame_reg[1] != HDR_CMD
                            || frame_reg[2] != HDR_LEN) begin
                        res_next.err = ERR_HEADER;
                    end else if (frame_reg[3] == STAT_HANDSOFF) begin
                        res_next.err = ERR_HANDS_OFF;
                    end else if (in_byte != expect_csum) begin
                        res_next.err = ERR_CHECKSUM;
                    end
                    res_next.kind = (res_next.err != ERR_NONE) ? KIND_REJECTED : KIND_READING;
                end
            end
            MODE_START: begin
                if (in_sel != CMD_NONE) begin
                    cmd_next    = in_sel;
                    tx_idx_next = '0;
                    rx_pos_next = '0;
                end
            end
            MODE_PULL: begin
                if (!tx_idx_reg[2]) begin
                    res_next.kind    = KIND_TX_BYTE;
                    res_next.tx_byte = cmd_byte(cmd_reg, tx_idx_reg[1:0]);
                    tx_idx_next      = tx_idx_reg + 3'd1;
                end else begin
                    res_next.kind = KIND_TX_DONE;
                    cmd_next      = CMD_NONE;
                end
            end
            default: begin
                res_next.kind = KIND_ACCEPTED;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_pos_reg    <= '0;
            cmd_reg       <= CMD_RESET;
            tx_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                rx_pos_reg <= rx_pos_next;
                cmd_reg    <= cmd_next;
                tx_idx_reg <= tx_idx_next;
            end
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: frame bytes and result word
    always_ff @(posedge aclk) begin
        if (accept && store_we) begin
            frame_reg[rx_pos_reg] <= in_byte;
        end
        if (accept) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, res_reg.err, res_reg.val_dec, res_reg.val_int,
                       res_reg.minutes, res_reg.status, res_reg.tx_byte, res_reg.kind};

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted word produced no result");

    a_tx_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tx_idx_reg <= 3'(CMD_LEN))
        else $error("transmit index past command length");

    a_cmd_while_sending: assert property (@(posedge aclk) disable iff (!aresetn)
        !tx_idx_reg[2] |-> cmd_reg != CMD_NONE)
        else $error("no command selected while bytes remain");

    a_err_matches_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((res_reg.kind == KIND_REJECTED) == (res_reg.err != ERR_NONE)))
        else $error("error code disagrees with result kind");

    a_frame_resync: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_mode == MODE_RX_BYTE && rx_pos_reg == 3'(FRAME_LEN-1)
        |=> rx_pos_reg == 3'd0)
        else $error("receive position not cleared after full frame");

endmodule

// ===== sim/radon_sensor_uart_frame_handler_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for radon_sensor_uart_frame_handler: command transmit pulls and
// 8-byte frame checks, predicted in-line and compared word by word on the m_ side.
// Depends on rsufh_pkg and the handler RTL.
module radon_sensor_uart_frame_handler_test;
    import rsufh_pkg::*;

    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         RANDOM_WORDS = 900;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    // Command bytes per command code, in send order
    localparam logic [0:3][0:3][7:0] COMMAND_BYTES = {
        32'h020100FE, 32'h02A0005F, 32'h02A1015D, 32'h00000000
    };

    typedef struct {
        kind_t      kind;
        logic [7:0] tx_byte;
        logic [7:0] status;
        logic [7:0] minutes;
        logic [7:0] val_int;
        logic [7:0] val_dec;
        err_t       err;
    } link_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // Link state as the handler should hold it
    logic [7:0] frame_bytes [7];
    logic [2:0] frame_pos  = 3'd0;
    logic [1:0] active_cmd = CMD_RESET;
    logic [2:0] tx_index   = 3'd0;

    link_result_t expected_link_results [$];
    int           mismatch_count = 0;
    int           sent_words     = 0;
    int           cycle_count    = 0;
    logic         quiet_stretch  = 1'b0;

    radon_sensor_uart_frame_handler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [7:0] frame_checksum(input logic [7:0] st, input logic [7:0] mn,
                                                  input logic [7:0] vi, input logic [7:0] vd);
        return CSUM_BASE - (HDR_CMD + HDR_LEN + st + mn + vi + vd);
    endfunction

    function automatic link_result_t predict_link_step(input logic [1:0] mode,
                                                       input logic [1:0] sel,
                                                       input logic [7:0] b);
        link_result_t r;
        r.kind    = KIND_ACCEPTED;
        r.tx_byte = 8'h00;
        r.status  = 8'h00;
        r.minutes = 8'h00;
        r.val_int = 8'h00;
        r.val_dec = 8'h00;
        r.err     = ERR_NONE;
        case (mode)
            MODE_RX_BYTE: begin
                if (frame_pos < 3'd7) begin
                    frame_bytes[frame_pos] = b;
                    frame_pos++;
                end else begin
                    // eighth byte: check the frame and resync
                    frame_pos = 3'd0;
                    r.status  = frame_bytes[3];
                    r.minutes = frame_bytes[4];
                    r.val_int = frame_bytes[5];
                    r.val_dec = frame_bytes[6];
                    if (frame_bytes[0] != HDR_START || frame_bytes[1] != HDR_CMD ||
                        frame_bytes[2] != HDR_LEN) begin
                        r.err = ERR_HEADER;
                    end else if (r.status == STAT_HANDSOFF) begin
                        r.err = ERR_HANDS_OFF;
                    end else if (b != frame_checksum(r.status, r.minutes, r.val_int,
                                                     r.val_dec)) begin
                        r.err = ERR_CHECKSUM;
                    end
                    if (r.err == ERR_NONE) begin
                        r.kind = KIND_READING;
                    end else begin
                        r.kind = KIND_REJECTED;
                    end
                end
            end
            MODE_START: begin
                if (sel != CMD_NONE) begin
                    active_cmd = sel;
                    tx_index   = 3'd0;
                    frame_pos  = 3'd0;
                end
            end
            MODE_PULL: begin
                if (tx_index < 3'(CMD_LEN)) begin
                    r.kind    = KIND_TX_BYTE;
                    r.tx_byte = COMMAND_BYTES[active_cmd][tx_index[1:0]];
                    tx_index++;
                end else begin
                    r.kind     = KIND_TX_DONE;
                    active_cmd = CMD_NONE;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic send_word(input logic [1:0] mode, input logic [1:0] sel,
                             input logic [7:0] b);
        while (!quiet_stretch && $urandom_range(0, 99) < 15) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, b, sel, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_link_results.push_back(predict_link_step(mode, sel, b));
        sent_words++;
    endtask

    task automatic send_frame(input logic [7:0] h0, input logic [7:0] h1, input logic [7:0] h2,
                              input logic [7:0] st, input logic [7:0] mn, input logic [7:0] vi,
                              input logic [7:0] vd, input logic [7:0] ck);
        send_word(MODE_RX_BYTE, 2'd0, h0);
        send_word(MODE_RX_BYTE, 2'd0, h1);
        send_word(MODE_RX_BYTE, 2'd0, h2);
        send_word(MODE_RX_BYTE, 2'd0, st);
        send_word(MODE_RX_BYTE, 2'd0, mn);
        send_word(MODE_RX_BYTE, 2'd0, vi);
        send_word(MODE_RX_BYTE, 2'd0, vd);
        send_word(MODE_RX_BYTE, 2'd0, ck);
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        link_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_link_results.size() == 0) begin
                $display("%0t: result word with none pending, expected nothing, actual %h",
                         $time, m_tdata);
                mismatch_count++;
            end else begin
                want = expected_link_results.pop_front();
                check_field("result_kind", {5'b0, want.kind}, {5'b0, m_tdata[2:0]});
                check_field("tx_byte", want.tx_byte, m_tdata[10:3]);
                check_field("sensor_status", want.status, m_tdata[18:11]);
                check_field("elapsed_minutes", want.minutes, m_tdata[26:19]);
                check_field("value_integer", want.val_int, m_tdata[34:27]);
                check_field("value_decimal", want.val_dec, m_tdata[42:35]);
                check_field("error_code", {6'b0, want.err}, {6'b0, m_tdata[44:43]});
            end
        end
        m_tready <= quiet_stretch || ($urandom_range(0, 99) >= 15);
    end

    // Reset command is selected out of reset; pull it out, then past the finish
    task automatic test_reset_command();
        repeat (6) send_word(MODE_PULL, CMD_NONE, 8'hFF);
    endtask

    task automatic test_unused_codes();
        send_word(MODE_START, CMD_NONE, 8'h00);
        send_word(MODE_UNUSED, CMD_NONE, 8'hFF);
        send_word(MODE_START, CMD_PERIOD, 8'h00);
        send_word(MODE_PULL, CMD_REQUEST, 8'h00);
    endtask

    task automatic test_good_frame();
        send_frame(HDR_START, HDR_CMD, HDR_LEN, 8'hFF, 8'h00, 8'hFF, 8'h00,
                   frame_checksum(8'hFF, 8'h00, 8'hFF, 8'h00));
    endtask

    // Start in the middle of a frame drops the partial bytes
    task automatic test_restart_mid_frame();
        send_word(MODE_RX_BYTE, 2'd0, HDR_START);
        send_word(MODE_RX_BYTE, 2'd0, HDR_CMD);
        send_word(MODE_RX_BYTE, 2'd0, HDR_LEN);
        send_word(MODE_START, CMD_REQUEST, 8'h55);
        send_word(MODE_PULL, CMD_PERIOD, 8'hAA);
    endtask

    task automatic test_random_traffic();
        int         scenario;
        int         start_words;
        int         bad_byte;
        logic [7:0] hdr [3];
        logic [7:0] st, mn, vi, vd, ck;
        start_words = sent_words;
        while (sent_words - start_words < RANDOM_WORDS) begin
            quiet_stretch = (sent_words - start_words) inside {[300:499]};
            scenario = $urandom_range(0, 99);
            if (scenario < 55) begin
                // realign before a frame, which may carry a bad header, hands-off status or checksum
                if (frame_pos != 3'd0) begin
                    send_word(MODE_START, 2'($urandom_range(0, 2)), 8'($urandom));
                end
                hdr[0] = HDR_START;
                hdr[1] = HDR_CMD;
                hdr[2] = HDR_LEN;
                if ($urandom_range(0, 99) < 15) begin
                    bad_byte = $urandom_range(0, 2);
                    hdr[bad_byte] = 8'($urandom);
                end
                st = ($urandom_range(0, 99) < 10) ? STAT_HANDSOFF : 8'($urandom);
                mn = 8'($urandom);
                vi = 8'($urandom);
                vd = 8'($urandom);
                ck = ($urandom_range(0, 99) < 75) ? frame_checksum(st, mn, vi, vd)
                                                   : 8'($urandom);
                send_frame(hdr[0], hdr[1], hdr[2], st, mn, vi, vd, ck);
            end else if (scenario < 70) begin
                send_word(MODE_START, 2'($urandom_range(0, 3)), 8'($urandom));
                repeat ($urandom_range(1, 6)) begin
                    send_word(MODE_PULL, 2'($urandom), 8'($urandom));
                end
            end else if (scenario < 80) begin
                repeat ($urandom_range(1, 7)) begin
                    send_word(MODE_RX_BYTE, 2'($urandom), 8'($urandom));
                end
                send_word(MODE_START, 2'($urandom_range(0, 2)), 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_word(2'($urandom), 2'($urandom), 8'($urandom));
                end
            end
        end
        quiet_stretch = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_command();
        test_unused_codes();
        test_good_frame();
        test_restart_mid_frame();
        test_random_traffic();
        s_tvalid <= 1'b0;
        while (expected_link_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
